### src/amf_pkg.sv
// ----------------------------------------------------------------------------
// amf_pkg
// shared widths and limits for the array mode finder
// ----------------------------------------------------------------------------
package amf_pkg;

    localparam int VALUE_W       = 32;
    localparam int MODE_COUNT_W  = 9;
    localparam int COUNT_SAT     = 511;
    localparam int MAX_ITEMS_DEF = 256;

endpackage

### src/array_mode_finder_unit.sv
// ----------------------------------------------------------------------------
// array_mode_finder_unit
// stores a list of signed values and reports the most frequent one
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_value, i_last_item
//  out     | o_out_valid | i_out_stall | o_mode_value, o_mode_count, o_overflow
//
//  loading accepts one beat per cycle; the store has one write and one read port
//  after the last beat, the stored items are counted against each candidate through
//  the single read port and one comparator, then the result waits on o_out_valid
//  input stays stalled from the last beat until the result beat is taken
//  synchronous active-low reset clears the state, fill count and overflow flag;
//  the store keeps its contents
//
module array_mode_finder_unit
    import amf_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [VALUE_W-1:0]      i_value,
    input  logic                           i_last_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [VALUE_W-1:0]      o_mode_value,
    output logic        [MODE_COUNT_W-1:0] o_mode_count,
    output logic                           o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = (CW > MODE_COUNT_W) ? CW : MODE_COUNT_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CAND,
        S_CWAIT,
        S_SCAN,
        S_TAIL,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [VALUE_W-1:0]  r_mem [MAX_ITEMS];
    logic [VALUE_W-1:0]  r_rd_data;
    logic [VALUE_W-1:0]  r_cand;
    logic [VALUE_W-1:0]  r_best_val;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_best_cnt;
    logic [AW-1:0]       r_i;
    logic [AW-1:0]       r_j;
    logic                r_cmp_v;
    logic                r_ovf;

    logic                in_beat;
    logic                store_full;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       fill_m1;
    logic [AW-1:0]       last_idx;
    logic [CW-1:0]       n_cnt;
    logic [XW-1:0]       best_x;

    assign in_beat    = i_in_valid && (r_state == S_LOAD);
    assign store_full = (r_fill == CW'(MAX_ITEMS));
    assign wr_en      = in_beat && !store_full;
    assign fill_m1    = r_fill - 1'b1;
    assign last_idx   = fill_m1[AW-1:0];
    assign rd_addr    = (r_state == S_SCAN) ? r_j : r_i;
    assign n_cnt      = r_cnt + CW'(r_cmp_v && (r_rd_data == r_cand));

    assign o_in_stall   = (r_state != S_LOAD);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_mode_value = $signed(r_best_val);
    assign o_overflow   = r_ovf;
    assign best_x       = XW'(r_best_cnt);
    assign o_mode_count = (best_x > XW'(COUNT_SAT)) ? MODE_COUNT_W'(COUNT_SAT)
                                                    : best_x[MODE_COUNT_W-1:0];

    // value store: one write port while loading, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= i_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_cmp_v <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_beat) begin
                        if (store_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (i_last_item) begin
                            r_i        <= '0;
                            r_best_cnt <= '0;
                            r_best_val <= '0;
                            r_state    <= S_CAND;
                        end
                    end
                end
                S_CAND: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    r_cand  <= r_rd_data;
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_cmp_v <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // compare works on the registered read data of the address before
                    r_cmp_v <= 1'b1;
                    r_cnt   <= n_cnt;
                    r_j     <= r_j + 1'b1;
                    if (r_j == last_idx) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    // strictly greater keeps the earliest value on ties
                    if (n_cnt > r_best_cnt) begin
                        r_best_cnt <= n_cnt;
                        r_best_val <= r_cand;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == last_idx) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_fill  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fill != '0) && (r_best_cnt != '0))
        else $error("result beat with empty list or zero count");

    a_best_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_best_cnt <= r_fill))
        else $error("mode count exceeds stored items");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (r_fill == '0) && !r_ovf)
        else $error("list state not cleared after result beat");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j <= last_idx) && (r_i <= last_idx))
        else $error("scan index beyond stored items");
`endif

endmodule
